FILE: rtl/cmac_pkg.sv
// Shared types, operation codes and saturation helpers for the Q1.15 complex MAC.
package cmac_pkg;

   localparam int SampleWidth = 16;
   localparam int ProductWidth = 2 * SampleWidth;
   localparam int FracBits = 15;

   typedef logic signed [SampleWidth-1:0] sample_type;

   typedef enum logic [1:0] {
      OP_MUL  = 2'd0,
      OP_MAC  = 2'd1,
      OP_CMUL = 2'd2,
      OP_CMAC = 2'd3
   } operation_type;

   // Lane negation: the 16-bit two's complement negate leaves -32768 as -32768.
   function automatic sample_type lane_neg(input sample_type x);
      lane_neg = sample_type'(-x);
   endfunction

   // Clamp a 17-bit signed value to the int16 range.
   function automatic sample_type sat17(input logic signed [SampleWidth:0] v);
      if (v[SampleWidth] != v[SampleWidth-1]) begin
         sat17 = v[SampleWidth] ? sample_type'({1'b1, {(SampleWidth-1){1'b0}}})
                                : sample_type'({1'b0, {(SampleWidth-1){1'b1}}});
      end else begin
         sat17 = v[SampleWidth-1:0];
      end
   endfunction

endpackage

FILE: rtl/q15_complex_multiply_accumulate.sv
// Top level of the Q1.15 complex multiply / multiply-accumulate stream block.
// Takes one request per clock unless stalled: factors a and b, a prior sample and an
// operation (multiply, multiply-accumulate, conjugate multiply b*conj(a), conjugate
// multiply-accumulate). Each request passes an input register, one pass of four
// 16x16 multipliers with a wrapped 32-bit sum, a >>15 shift and int16 saturation
// (plus a saturating add of the prior sample in accumulate modes), and a result
// register. rsp_tvalid rises once the request has moved from the input register to the
// result register, which happens when that register is empty or being taken; a new
// request is accepted every clock unless both registers are full. Up to two requests
// are held while rsp_tready is low. No configuration and no state beyond the
// pipeline; tlast rides along unchanged.
module q15_complex_multiply_accumulate
   import cmac_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // a_re[15:0], a_im[31:16], b_re[47:32], b_im[63:48], prior_re[79:64], prior_im[95:80]
   input  logic [95:0] req_tdata,
   // operation[1:0]
   input  logic [1:0]  req_tuser,
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // res_re[15:0], res_im[31:16]
   output logic [31:0] rsp_tdata,
   output logic        rsp_tlast
);

   // Input stage
   logic          in_valid_ff, in_valid_in;
   operation_type op_ff;
   sample_type    a_re_ff, a_im_ff, b_re_ff, b_im_ff, prior_re_ff, prior_im_ff;
   logic          last_ff;

   // Result stage
   logic          out_valid_ff, out_valid_in;
   sample_type    res_re_ff, res_im_ff;
   logic          out_last_ff;

   logic          out_ready;
   logic          req_take;
   logic          in_move;

   logic          conj;
   logic          accumulate;
   sample_type    re_x1, im_y1;
   sample_type    res_re, res_im;

   // Advance the result register when it is empty or being taken.
   assign out_ready  = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || out_ready;
   assign req_take   = req_tvalid && req_tready;
   assign in_move    = in_valid_ff && out_ready;

   always_comb begin
      in_valid_in = req_take ? 1'b1 : (in_move ? 1'b0 : in_valid_ff);
      out_valid_in = out_ready ? in_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture the request payload.
   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff       <= operation_type'(req_tuser);
         a_re_ff     <= req_tdata[15:0];
         a_im_ff     <= req_tdata[31:16];
         b_re_ff     <= req_tdata[47:32];
         b_im_ff     <= req_tdata[63:48];
         prior_re_ff <= req_tdata[79:64];
         prior_im_ff <= req_tdata[95:80];
         last_ff     <= req_tlast;
      end
   end

   // Decode the operation.
   always_comb begin
      unique case (op_ff) inside
         OP_CMUL, OP_CMAC: conj = 1'b1;
         default:          conj = 1'b0;
      endcase
      unique case (op_ff) inside
         OP_MAC, OP_CMAC: accumulate = 1'b1;
         default:         accumulate = 1'b0;
      endcase
   end

   // multiply:  re = ar*br + neg(ai)*bi, im = ar*bi + ai*br
   // conjugate: re = ar*br + ai*bi,      im = ar*bi + ai*neg(br)
   assign re_x1 = conj ? a_im_ff : lane_neg(a_im_ff);
   assign im_y1 = conj ? lane_neg(b_re_ff) : b_re_ff;

   cmac_lane u_lane_re (
      .x0         (a_re_ff),
      .y0         (b_re_ff),
      .x1         (re_x1),
      .y1         (b_im_ff),
      .prior      (prior_re_ff),
      .accumulate (accumulate),
      .result     (res_re)
   );

   cmac_lane u_lane_im (
      .x0         (a_re_ff),
      .y0         (b_im_ff),
      .x1         (a_im_ff),
      .y1         (im_y1),
      .prior      (prior_im_ff),
      .accumulate (accumulate),
      .result     (res_im)
   );

   // Hold the result while the consumer stalls.
   always_ff @(posedge clock) begin
      if (in_move) begin
         res_re_ff   <= res_re;
         res_im_ff   <= res_im;
         out_last_ff <= last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {res_im_ff, res_re_ff};
   assign rsp_tlast  = out_last_ff;

`ifndef ASSERT_OFF
   // Input is refused only when both stages are full.
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && out_valid_ff))
      else $error("req_tready low with a free stage");

   // An item in the input stage moves to the result stage, never vanishes.
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_ready) |=> out_valid_ff)
      else $error("request lost between stages");

   // A stalled result keeps the input stage item in place.
   a_hold_in: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_tready) |=> in_valid_ff)
      else $error("input stage dropped while result stalled");
`endif

endmodule

FILE: rtl/cmac_lane.sv
// One part of the complex product: two products, wrapped sum, shift, saturate, accumulate.
module cmac_lane
   import cmac_pkg::*;
(
   input  sample_type x0,
   input  sample_type y0,
   input  sample_type x1,
   input  sample_type y1,
   input  sample_type prior,
   input  logic       accumulate,
   output sample_type result
);

   logic signed [ProductWidth-1:0] prod0;
   logic signed [ProductWidth-1:0] prod1;
   logic signed [ProductWidth-1:0] sum_wrap;
   logic signed [SampleWidth:0]    shifted;
   sample_type                     prod_sat;
   logic signed [SampleWidth:0]    acc_sum;

   assign prod0 = ProductWidth'(x0) * ProductWidth'(y0);
   assign prod1 = ProductWidth'(x1) * ProductWidth'(y1);
   // 32-bit sum wraps only when both products are +2^30
   assign sum_wrap = prod0 + prod1;
   assign shifted = sum_wrap[ProductWidth-1:FracBits];
   assign prod_sat = sat17(shifted);
   assign acc_sum = {prod_sat[SampleWidth-1], prod_sat} + {prior[SampleWidth-1], prior};
   assign result = accumulate ? sat17(acc_sum) : prod_sat;

endmodule
